FILE: hw/rtl/irlm_pkg.sv
// Shared types and constants for the idle-ratio load monitor.
// Holds the command and state encodings and the default widths.
// No dependencies; every other file refers to it by scoped names.
package irlm_pkg;

  // Default parameter values and fixed field widths
  localparam int unsigned COUNTER_BITS_DEFAULT  = 32;
  localparam int unsigned FRACTION_BITS_DEFAULT = 16;
  localparam int unsigned CYCLE_W               = 32;
  localparam int unsigned CMD_W                 = 2;
  localparam int unsigned LOAD_OUT_W            = 23;
  localparam int unsigned ALPHA_W               = 16;

  // Integer part of a load in percent: 100 needs seven bits.
  localparam int unsigned PERCENT_INT_W = 7;
  localparam int unsigned PERCENT_FULL  = 100;

  // Alpha after reset is 0.2 in Q0.16.
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd13107;

  // Commands carried by an input beat
  typedef enum logic [CMD_W-1:0] {
    CMD_IDLE_ENTER = 2'd0,
    CMD_IDLE_EXIT  = 2'd1,
    CMD_SAMPLE     = 2'd2,
    CMD_CLEAR      = 2'd3
  } cmd_t;

  // Top-level control states
  typedef enum logic {
    TOP_READY,
    TOP_WAIT
  } top_state_t;

  // Serial load and average unit states
  typedef enum logic [2:0] {
    EMA_IDLE,
    EMA_PREP,
    EMA_SCALE,
    EMA_RUN,
    EMA_SUM
  } ema_state_t;

  // Status returned by the serial unit
  typedef struct packed {
    logic busy;
    logic done;
  } ema_sts_t;

endpackage

FILE: hw/rtl/irlm_in_if.sv
// Input channel of the idle-ratio load monitor: command and counter sample.
// Depends on irlm_pkg for the field widths.
interface irlm_in_if;
  logic                          valid;
  logic                          ready;
  logic [irlm_pkg::CMD_W-1:0]    command;
  logic [irlm_pkg::CYCLE_W-1:0]  cycle_count;

  modport source (output valid, output command, output cycle_count, input ready);
  modport sink   (input valid, input command, input cycle_count, output ready);
endinterface

FILE: hw/rtl/irlm_out_if.sv
// Result channel of the idle-ratio load monitor: smoothed load and flag.
// Depends on irlm_pkg for the field widths.
interface irlm_out_if;
  logic                            valid;
  logic                            ready;
  logic [irlm_pkg::LOAD_OUT_W-1:0] smoothed_load;
  logic                            load_valid;

  modport source (output valid, output smoothed_load, output load_valid, input ready);
  modport sink   (input valid, input smoothed_load, input load_valid, output ready);
endinterface

FILE: hw/rtl/irlm_ema_unit.sv
// Bit-serial load computation and moving-average update.
// A restoring divider yields the load one quotient bit per cycle, which feeds
// a serial alpha multiply; the old average is weighted by a second one.
// Depends on irlm_pkg.
module irlm_ema_unit #(
  parameter int unsigned COUNTER_BITS  = irlm_pkg::COUNTER_BITS_DEFAULT,
  parameter int unsigned FRACTION_BITS = irlm_pkg::FRACTION_BITS_DEFAULT
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  logic                                             start,
  input  logic [COUNTER_BITS-1:0]                          span_cycles,
  input  logic [COUNTER_BITS-1:0]                          idle_cycles,
  input  logic [irlm_pkg::ALPHA_W-1:0]                     alpha,
  input  logic [irlm_pkg::PERCENT_INT_W+FRACTION_BITS-1:0] old_avg,
  output irlm_pkg::ema_sts_t                               sts,
  output logic [irlm_pkg::PERCENT_INT_W+FRACTION_BITS-1:0] new_avg
);

  localparam int unsigned CB      = COUNTER_BITS;
  localparam int unsigned AW      = irlm_pkg::ALPHA_W;
  localparam int unsigned PIW     = irlm_pkg::PERCENT_INT_W;
  localparam int unsigned LW      = PIW + FRACTION_BITS;
  localparam int unsigned STEPS   = (LW > AW) ? LW : AW;
  localparam int unsigned CNT_W   = $clog2(STEPS + 1);
  localparam int unsigned PW      = LW + AW;
  localparam int unsigned SW      = CB + PIW;
  localparam int unsigned SUM_W   = LW + 1;

  irlm_pkg::ema_state_t state_r, state_nxt;
  logic [CB-1:0]    total_r, total_nxt;
  logic [CB-1:0]    idle_r, idle_nxt;
  logic [CB-1:0]    busy_r, busy_nxt;
  logic             zero_r, zero_nxt;
  logic [CB-1:0]    rem_r, rem_nxt;
  logic [LW-1:0]    num_sh_r, num_sh_nxt;
  logic [PW-1:0]    acc_a_r, acc_a_nxt;
  logic [PW-1:0]    acc_b_r, acc_b_nxt;
  logic [AW-1:0]    alpha_r, alpha_nxt;
  logic [AW-1:0]    alpha_sh_r, alpha_sh_nxt;
  logic [LW-1:0]    old_r, old_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic [CB:0]      diff;
  logic [SW-1:0]    scaled;
  logic [CB:0]      trial;
  logic [CB:0]      trial_sub;
  logic             ge;
  logic             qbit;
  logic [PW-1:0]    acc_a_step;
  logic [PW-1:0]    acc_b_step;
  logic [PW-1:0]    keep;
  logic [SUM_W-1:0] sum;

  // Busy cycles and the zero-load test share one subtractor.
  assign diff = {1'b0, total_r} - {1'b0, idle_r};

  // busy * 100 as shifted adds: 64 + 32 + 4.
  assign scaled = (SW'(busy_r) << 6) + (SW'(busy_r) << 5) + (SW'(busy_r) << 2);

  // One restoring division step; the numerator enters MSB first.
  assign trial     = {rem_r, num_sh_r[LW-1]};
  assign ge        = (trial >= {1'b0, total_r});
  assign trial_sub = trial - {1'b0, total_r};
  assign qbit      = ge && !zero_r;

  // Quotient bits drive the alpha product MSB first; alpha bits drive the
  // product with the old average.
  assign acc_a_step = {acc_a_r[PW-2:0], 1'b0} + (qbit ? PW'(alpha_r) : '0);
  assign acc_b_step = {acc_b_r[PW-2:0], 1'b0} + (alpha_sh_r[AW-1] ? PW'(old_r) : '0);

  // (2^16 - alpha) * old, each product truncated on its own.
  assign keep    = {old_r, {AW{1'b0}}} - acc_b_r;
  assign sum     = SUM_W'(acc_a_r[PW-1:AW]) + SUM_W'(keep[PW-1:AW]);
  assign new_avg = sum[LW-1:0];

  assign sts.busy = (state_r != irlm_pkg::EMA_IDLE);
  assign sts.done = (state_r == irlm_pkg::EMA_SUM);

  // Sequencer and datapath next values
  always_comb begin
    state_nxt    = state_r;
    total_nxt    = total_r;
    idle_nxt     = idle_r;
    busy_nxt     = busy_r;
    zero_nxt     = zero_r;
    rem_nxt      = rem_r;
    num_sh_nxt   = num_sh_r;
    acc_a_nxt    = acc_a_r;
    acc_b_nxt    = acc_b_r;
    alpha_nxt    = alpha_r;
    alpha_sh_nxt = alpha_sh_r;
    old_nxt      = old_r;
    cnt_nxt      = cnt_r;
    unique case (state_r)
      irlm_pkg::EMA_IDLE: begin
        if (start) begin
          total_nxt = span_cycles;
          idle_nxt  = idle_cycles;
          alpha_nxt = alpha;
          old_nxt   = old_avg;
          state_nxt = irlm_pkg::EMA_PREP;
        end
      end
      irlm_pkg::EMA_PREP: begin
        // Load is zero for an empty interval or when idle covers it all.
        busy_nxt  = diff[CB-1:0];
        zero_nxt  = diff[CB] || (diff[CB-1:0] == '0);
        state_nxt = irlm_pkg::EMA_SCALE;
      end
      irlm_pkg::EMA_SCALE: begin
        // The top bits of busy*100 are already below the total, so they
        // seed the remainder and only the low bits remain to shift in.
        rem_nxt      = scaled[SW-1:PIW];
        num_sh_nxt   = {scaled[PIW-1:0], {FRACTION_BITS{1'b0}}};
        acc_a_nxt    = '0;
        acc_b_nxt    = '0;
        alpha_sh_nxt = alpha_r;
        cnt_nxt      = '0;
        state_nxt    = irlm_pkg::EMA_RUN;
      end
      irlm_pkg::EMA_RUN: begin
        if (cnt_r < CNT_W'(LW)) begin
          rem_nxt    = ge ? trial_sub[CB-1:0] : trial[CB-1:0];
          num_sh_nxt = {num_sh_r[LW-2:0], 1'b0};
          acc_a_nxt  = acc_a_step;
        end
        if (cnt_r < CNT_W'(AW)) begin
          acc_b_nxt    = acc_b_step;
          alpha_sh_nxt = {alpha_sh_r[AW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(STEPS - 1)) begin
          state_nxt = irlm_pkg::EMA_SUM;
        end
      end
      irlm_pkg::EMA_SUM: begin
        state_nxt = irlm_pkg::EMA_IDLE;
      end
      default: begin
        state_nxt = irlm_pkg::EMA_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= irlm_pkg::EMA_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    total_r    <= total_nxt;
    idle_r     <= idle_nxt;
    busy_r     <= busy_nxt;
    zero_r     <= zero_nxt;
    rem_r      <= rem_nxt;
    num_sh_r   <= num_sh_nxt;
    acc_a_r    <= acc_a_nxt;
    acc_b_r    <= acc_b_nxt;
    alpha_r    <= alpha_nxt;
    alpha_sh_r <= alpha_sh_nxt;
    old_r      <= old_nxt;
  end

endmodule

FILE: hw/rtl/idle_ratio_load_monitor_core.sv
// Top level of the idle-ratio load monitor: handshakes, idle accounting,
// baseline tracking and the result register.
// Depends on irlm_pkg, irlm_in_if, irlm_out_if and irlm_ema_unit.
//
//   Channel  Direction  Contents                          Handshake
//   in_ch    sink       command, cycle_count              valid/ready
//   out_ch   source     smoothed_load, load_valid         valid/ready
//   cfg_*    input      ema_alpha (16 bits)               write enable, no stall
//
// Idle enter, idle exit, clear and the first sample are answered from TOP_READY.
// A sample after the baseline runs the serial unit in irlm_ema_unit through
// EMA_PREP, EMA_SCALE, EMA_RUN and EMA_SUM; the result is registered when the
// unit reports done; no new beat is taken until the top is back in TOP_READY
// with the result slot free, so one sample finishes before the next is taken.
// One beat in, one beat out; a result the sink has not taken blocks a new beat.
// Synchronous active-low reset: alpha returns to 0.2, other control state to zero.
module idle_ratio_load_monitor_core #(
  parameter int unsigned COUNTER_BITS  = irlm_pkg::COUNTER_BITS_DEFAULT,
  parameter int unsigned FRACTION_BITS = irlm_pkg::FRACTION_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [irlm_pkg::ALPHA_W-1:0]  cfg_wdata,
  irlm_in_if.sink                       in_ch,
  irlm_out_if.source                    out_ch
);

  localparam int unsigned CB    = COUNTER_BITS;
  localparam int unsigned LW    = irlm_pkg::PERCENT_INT_W + FRACTION_BITS;
  localparam int unsigned OUT_W = irlm_pkg::LOAD_OUT_W;
  localparam logic [LW-1:0] LOAD_FULL = LW'(irlm_pkg::PERCENT_FULL) << FRACTION_BITS;

  irlm_pkg::top_state_t state_r, state_nxt;
  logic [irlm_pkg::ALPHA_W-1:0] alpha_r, alpha_nxt;
  logic [CB-1:0]    idle_acc_r, idle_acc_nxt;
  logic [CB-1:0]    entry_r, entry_nxt;
  logic             in_idle_r, in_idle_nxt;
  logic [CB-1:0]    prev_total_r, prev_total_nxt;
  logic [CB-1:0]    prev_idle_r, prev_idle_nxt;
  logic [LW-1:0]    avg_r, avg_nxt;
  logic             base_r, base_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_load_r, out_load_nxt;
  logic             out_lv_r, out_lv_nxt;

  irlm_pkg::cmd_t     cmd;
  irlm_pkg::ema_sts_t ema_sts;
  logic [CB-1:0]      now;
  logic               accept;
  logic               out_free;
  logic               ema_start;
  logic [CB-1:0]      span_cycles;
  logic [CB-1:0]      idle_cycles;
  logic [LW-1:0]      ema_avg;

  assign cmd      = irlm_pkg::cmd_t'(in_ch.command);
  assign now      = CB'(in_ch.cycle_count);
  assign out_free = !out_valid_r || out_ch.ready;
  assign accept   = in_ch.valid && in_ch.ready;

  assign in_ch.ready          = (state_r == irlm_pkg::TOP_READY) && out_free;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.smoothed_load = out_load_r;
  assign out_ch.load_valid    = out_lv_r;

  // Elapsed counts since the previous sample, both wrapping.
  assign span_cycles = now - prev_total_r;
  assign idle_cycles = idle_acc_r - prev_idle_r;

  irlm_ema_unit #(
    .COUNTER_BITS  (COUNTER_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_ema (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (ema_start),
    .span_cycles (span_cycles),
    .idle_cycles (idle_cycles),
    .alpha       (alpha_r),
    .old_avg     (avg_r),
    .sts         (ema_sts),
    .new_avg     (ema_avg)
  );

  // Command handling, result register and control state
  always_comb begin
    state_nxt      = state_r;
    alpha_nxt      = alpha_r;
    idle_acc_nxt   = idle_acc_r;
    entry_nxt      = entry_r;
    in_idle_nxt    = in_idle_r;
    prev_total_nxt = prev_total_r;
    prev_idle_nxt  = prev_idle_r;
    avg_nxt        = avg_r;
    base_nxt       = base_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_load_nxt   = out_load_r;
    out_lv_nxt     = out_lv_r;
    ema_start      = 1'b0;

    if (cfg_we) begin
      alpha_nxt = cfg_wdata;
    end

    unique case (state_r)
      irlm_pkg::TOP_READY: begin
        if (accept) begin
          unique case (cmd)
            irlm_pkg::CMD_IDLE_ENTER: begin
              // A second enter keeps the first entry time.
              if (!in_idle_r) begin
                entry_nxt   = now;
                in_idle_nxt = 1'b1;
              end
            end
            irlm_pkg::CMD_IDLE_EXIT: begin
              if (in_idle_r) begin
                idle_acc_nxt = idle_acc_r + (now - entry_r);
                in_idle_nxt  = 1'b0;
              end
            end
            irlm_pkg::CMD_SAMPLE: begin
              prev_total_nxt = now;
              prev_idle_nxt  = idle_acc_r;
              if (base_r) begin
                ema_start = 1'b1;
                state_nxt = irlm_pkg::TOP_WAIT;
              end else begin
                avg_nxt  = '0;
                base_nxt = 1'b1;
              end
            end
            irlm_pkg::CMD_CLEAR: begin
              idle_acc_nxt   = '0;
              avg_nxt        = '0;
              prev_total_nxt = '0;
              prev_idle_nxt  = '0;
              base_nxt       = 1'b0;
            end
            default: begin
            end
          endcase
          // Every beat except a full sample answers at once.
          if (!ema_start) begin
            out_valid_nxt = 1'b1;
            out_load_nxt  = base_nxt ? OUT_W'(avg_nxt) : '0;
            out_lv_nxt    = base_nxt;
          end
        end
      end
      irlm_pkg::TOP_WAIT: begin
        if (ema_sts.done) begin
          avg_nxt       = ema_avg;
          out_valid_nxt = 1'b1;
          out_load_nxt  = OUT_W'(ema_avg);
          out_lv_nxt    = 1'b1;
          state_nxt     = irlm_pkg::TOP_READY;
        end
      end
      default: begin
        state_nxt = irlm_pkg::TOP_READY;
      end
    endcase
  end

  // Control and monitor state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= irlm_pkg::TOP_READY;
      alpha_r      <= irlm_pkg::ALPHA_RESET;
      idle_acc_r   <= '0;
      entry_r      <= '0;
      in_idle_r    <= 1'b0;
      prev_total_r <= '0;
      prev_idle_r  <= '0;
      avg_r        <= '0;
      base_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      alpha_r      <= alpha_nxt;
      idle_acc_r   <= idle_acc_nxt;
      entry_r      <= entry_nxt;
      in_idle_r    <= in_idle_nxt;
      prev_total_r <= prev_total_nxt;
      prev_idle_r  <= prev_idle_nxt;
      avg_r        <= avg_nxt;
      base_r       <= base_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    out_load_r <= out_load_nxt;
    out_lv_r   <= out_lv_nxt;
  end

  // The serial unit only reports a result while the top waits for one.
  a_done_only_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    ema_sts.done |-> (state_r == irlm_pkg::TOP_WAIT))
    else $error("serial unit finished while no sample was pending");

  // The result slot is empty whenever a sample is in flight.
  a_slot_free_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == irlm_pkg::TOP_WAIT) |-> (!out_valid_r && ema_sts.busy))
    else $error("result slot occupied or unit idle during a sample");

  // The average never exceeds full load.
  a_avg_bound: assert property (@(posedge clk) disable iff (!rst_n)
    avg_r <= LOAD_FULL)
    else $error("average above 100 percent");

  // A result without a baseline carries a zero load.
  a_unflagged_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_lv_r) |-> (out_load_r == '0))
    else $error("nonzero load before baseline");

  // Leaving idle happens only on an accepted exit beat.
  a_idle_exit: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_idle_r) |-> $past(accept && (cmd == irlm_pkg::CMD_IDLE_EXIT)))
    else $error("idle flag dropped without an exit beat");

endmodule
